>>> sv/ulenc_pkg.sv
// Shared types and constants of the uuencode line encoder.
package ulenc_pkg;

  localparam int SumW  = 20;
  localparam int CfgW  = 6;
  localparam int GrpW  = 24;
  localparam int PendW = 16;

  localparam logic [CfgW-1:0] LinesPerSumReset = 6'd20;

  localparam logic [6:0] CharZero = 7'h60;
  localparam logic [6:0] CharBias = 7'h20;
  localparam logic [6:0] CharCr   = 7'h0D;
  localparam logic [6:0] CharLf   = 7'h0A;

  typedef enum logic {
    KIND_TEXT     = 1'b0,
    KIND_CHECKSUM = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [6:0]        text_char;
    logic [SumW-1:0]   checksum;
    logic              end_of_run;
  } out_item_t;

  // One processed byte as seen by the character generator.
  typedef struct packed {
    logic             hdr;
    logic             grp_v;
    logic [GrpW-1:0]  grp;
    logic             eol;
    logic [GrpW-1:0]  pad;
    logic             flush;
    logic [SumW-1:0]  sum;
    logic             eor;
  } cmd_t;

  function automatic logic [6:0] enc6(input logic [5:0] v);
    logic [6:0] c;
    if (v == 6'd0) begin
      c = CharZero;
    end else begin
      c = {1'b0, v} + CharBias;
    end
    return c;
  endfunction

endpackage

>>> sv/ulenc_front.sv
// Byte front end: line position, grouping, byte sum and zero fill after a last byte.
module ulenc_front #(
  parameter int LINE_BYTES = 45
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ulenc_pkg::in_item_t           in_data_i,
  input  logic [ulenc_pkg::CfgW-1:0]    lines_per_sum_i,
  input  logic                          full_i,
  output logic                          push_o,
  output ulenc_pkg::cmd_t               cmd_o
);

  localparam int PosW   = $clog2(LINE_BYTES + 1);
  localparam int PadRem = LINE_BYTES % 3;

  logic [PosW-1:0]               pos_q, pos_d;
  logic [1:0]                    r_q, r_d;
  logic [ulenc_pkg::PendW-1:0]   pend_q, pend_d;
  logic [ulenc_pkg::CfgW-1:0]    lc_q, lc_d;
  logic [ulenc_pkg::SumW-1:0]    sum_q, sum_d;
  logic                          fill_q, fill_d;

  logic                          take_in;
  logic                          step;
  logic [7:0]                    byte_v;
  logic                          last_v;
  logic [ulenc_pkg::PendW-1:0]   pend_n;
  logic [ulenc_pkg::SumW-1:0]    sum_n;
  logic [ulenc_pkg::CfgW-1:0]    lc_inc;
  logic [PosW-1:0]               pos_inc;
  logic                          eol;
  logic                          terminal;
  logic                          flush;
  ulenc_pkg::cmd_t               cmd;

  assign in_stall_o = fill_q || full_i;
  assign take_in    = in_valid_i && !in_stall_o;
  assign step       = take_in || (fill_q && !full_i);
  assign byte_v     = fill_q ? 8'h00 : in_data_i.data_byte;
  assign last_v     = take_in && in_data_i.last;

  assign sum_n    = sum_q + {{(ulenc_pkg::SumW-8){1'b0}}, byte_v};
  assign pos_inc  = pos_q + PosW'(1);
  assign eol      = (pos_inc == PosW'(LINE_BYTES));
  assign lc_inc   = lc_q + ulenc_pkg::CfgW'(1);
  assign terminal = eol && (fill_q || last_v);
  // A line count that wraps to zero matches a register value of zero.
  assign flush    = eol && ((lc_inc == lines_per_sum_i) || (terminal && lc_inc != '0));

  always_comb begin
    unique case (r_q)
      2'd0:    pend_n = {8'h00, byte_v};
      2'd1:    pend_n = {pend_q[7:0], byte_v};
      default: pend_n = pend_q;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.hdr   = (pos_q == '0);
    cmd.grp_v = (r_q == 2'd2);
    cmd.grp   = {pend_q, byte_v};
    cmd.eol   = eol;
    if (PadRem == 1) begin
      cmd.pad = {pend_n[7:0], 16'h0000};
    end else begin
      cmd.pad = {pend_n, 8'h00};
    end
    cmd.flush = flush;
    cmd.sum   = sum_n;
    // A last byte that leaves its line open hands the end of run to the final fill byte.
    cmd.eor   = eol || (take_in && !in_data_i.last);
  end

  assign cmd_o  = cmd;
  assign push_o = step && (cmd.hdr || cmd.grp_v || cmd.eol);

  always_comb begin
    pos_d  = pos_q;
    r_d    = r_q;
    pend_d = pend_q;
    lc_d   = lc_q;
    sum_d  = sum_q;
    fill_d = fill_q;
    if (step) begin
      sum_d  = flush ? '0 : sum_n;
      if (eol) begin
        pos_d  = '0;
        r_d    = 2'd0;
        pend_d = '0;
        lc_d   = flush ? '0 : lc_inc;
        fill_d = 1'b0;
      end else begin
        pos_d  = pos_inc;
        r_d    = (r_q == 2'd2) ? 2'd0 : r_q + 2'd1;
        pend_d = pend_n;
        // A last byte that leaves a line open starts the zero fill.
        fill_d = fill_q || last_v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      r_q    <= 2'd0;
      pend_q <= '0;
      lc_q   <= '0;
      sum_q  <= '0;
      fill_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      r_q    <= r_d;
      pend_q <= pend_d;
      lc_q   <= lc_d;
      sum_q  <= sum_d;
      fill_q <= fill_d;
    end
  end

endmodule

>>> sv/ulenc_cmd_fifo.sv
// Four-entry queue of byte commands between the front end and the character generator.
module ulenc_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ulenc_pkg::cmd_t  cmd_i,
  input  logic             pop_i,
  output ulenc_pkg::cmd_t  cmd_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  ulenc_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + PtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> sv/ulenc_back.sv
// Character generator: walks the slots of each command and drives the output register.
module ulenc_back #(
  parameter int LINE_BYTES = 45
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  ulenc_pkg::cmd_t      cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ulenc_pkg::out_item_t out_data_o
);

  localparam int  NumSlots = 12;
  localparam int  SlotW    = 4;
  localparam logic PadOn   = ((LINE_BYTES % 3) != 0);
  localparam logic [6:0] HdrChar = 7'(32 + LINE_BYTES);

  localparam logic [SlotW-1:0] SlotHdr     = 4'd0;
  localparam logic [SlotW-1:0] SlotGrpLast = 4'd4;
  localparam logic [SlotW-1:0] SlotPadLast = 4'd8;
  localparam logic [SlotW-1:0] SlotCr      = 4'd9;
  localparam logic [SlotW-1:0] SlotLf      = 4'd10;

  logic [SlotW-1:0]     slot_q, slot_d;
  logic                 out_valid_q, out_valid_d;
  ulenc_pkg::out_item_t out_q, out_d;

  logic                 load;
  logic [NumSlots-1:0]  present;
  logic [NumSlots-1:0]  remaining;
  logic [NumSlots-1:0]  rest;
  logic [SlotW-1:0]     cur;
  logic                 is_last;
  logic [ulenc_pkg::GrpW-1:0] word;
  logic [1:0]           digit;
  logic [5:0]           six;

  assign load = !out_valid_q || !out_stall_i;

  assign present = {cmd_i.flush, cmd_i.eol, cmd_i.eol, {4{cmd_i.eol & PadOn}},
                    {4{cmd_i.grp_v}}, cmd_i.hdr};
  assign remaining = present & ~((NumSlots'(1) << slot_q) - NumSlots'(1));

  always_comb begin
    cur = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        cur = SlotW'(i);
      end
    end
  end

  assign rest    = remaining & ~(NumSlots'(1) << cur);
  assign is_last = (rest == '0);

  always_comb begin
    if (cur <= SlotGrpLast) begin
      word  = cmd_i.grp;
      digit = 2'(cur - 4'd1);
    end else begin
      word  = cmd_i.pad;
      digit = 2'(cur - 4'd5);
    end
  end

  always_comb begin
    unique case (digit)
      2'd0:    six = word[23:18];
      2'd1:    six = word[17:12];
      2'd2:    six = word[11:6];
      default: six = word[5:0];
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    slot_d      = slot_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        out_d            = '0;
        out_d.kind       = ulenc_pkg::KIND_TEXT;
        out_d.end_of_run = is_last && cmd_i.eor;
        priority if (cur == SlotHdr) begin
          out_d.text_char = HdrChar;
        end else if (cur <= SlotPadLast) begin
          out_d.text_char = ulenc_pkg::enc6(six);
        end else if (cur == SlotCr) begin
          out_d.text_char = ulenc_pkg::CharCr;
        end else if (cur == SlotLf) begin
          out_d.text_char = ulenc_pkg::CharLf;
        end else begin
          out_d.kind     = ulenc_pkg::KIND_CHECKSUM;
          out_d.checksum = cmd_i.sum;
        end
        pop_o  = is_last;
        slot_d = is_last ? '0 : cur + SlotW'(1);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      slot_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      slot_q      <= slot_d;
    end
  end

endmodule

>>> sv/uuencode_line_encoder_core.sv
// Usage notes:
// Bytes enter on the input channel (in_valid_i, in_stall_o, in_data_i) and leave as
// uuencoded text on the output channel (out_valid_o, out_stall_i, out_data_o), one
// result per transfer: a length character, four characters per three bytes, CR and LF
// at each line end, and a checksum result after the configured number of lines or
// after a byte marked last. end_of_run flags the final result caused by one byte.
// The lines-per-checksum register is written over cfg_valid_i/cfg_data_i; cfg_ready_o
// is always high. A value of zero means 64 lines.
// With the queue empty, the first result of a byte is registered in a queue entry and
// then in the output register. The output side moves one result per cycle while
// out_stall_i is low, so throughput is set by the character generator. A four-entry
// command queue lets the front end take a byte every cycle while the queue has room
// and no zero fill runs. A byte marked last in mid-line makes the front end insert zero
// bytes to finish the line, one per cycle while the queue has room, with in_stall_o
// held high.
// Reset clears the line position, sums and queue; the register returns to 20.
// While out_stall_i is high the output result holds and the queue fills, after which
// in_stall_o rises.
module uuencode_line_encoder_core #(
  parameter int LINE_BYTES = 45
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ulenc_pkg::in_item_t         in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ulenc_pkg::out_item_t        out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ulenc_pkg::CfgW-1:0]  cfg_data_i
);

  logic [ulenc_pkg::CfgW-1:0] lines_q, lines_d;
  logic                       push;
  logic                       pop;
  logic                       full;
  logic                       empty;
  ulenc_pkg::cmd_t            cmd_in;
  ulenc_pkg::cmd_t            cmd_out;

  assign cfg_ready_o = 1'b1;
  assign lines_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : lines_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q <= ulenc_pkg::LinesPerSumReset;
    end else begin
      lines_q <= lines_d;
    end
  end

  ulenc_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .lines_per_sum_i(lines_q),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (cmd_in)
  );

  ulenc_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_out),
    .full_o (full),
    .empty_o(empty)
  );

  ulenc_back #(
    .LINE_BYTES(LINE_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .cmd_i      (cmd_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> sv/ulenc_checker.sv
// Port-level checks of the uuencode line encoder, bound to the top level.
module ulenc_assert (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input ulenc_pkg::out_item_t        out_data_o
);

  logic out_xfer;
  assign out_xfer = out_valid_o && !out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output result changed");

  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.kind == ulenc_pkg::KIND_CHECKSUM) ?
      (out_data_o.text_char == '0) : (out_data_o.checksum == '0))
    else $error("unused result field not zero");

  // LF is generated in the cycle right after CR leaves.
  a_cr_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_data_o.kind == ulenc_pkg::KIND_TEXT &&
      out_data_o.text_char == ulenc_pkg::CharCr
    |=> out_valid_o && out_data_o.text_char == ulenc_pkg::CharLf)
    else $error("CR not followed by LF");

  // A checksum is always the final result caused by its byte.
  a_sum_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == ulenc_pkg::KIND_CHECKSUM
    |-> out_data_o.end_of_run)
    else $error("checksum result without end_of_run");

endmodule

bind uuencode_line_encoder_core ulenc_assert u_assert (.*);

>>> verif/ulenc_checker.sv
// Predicts the encoded line stream of the uuencode line encoder and checks every output transfer.
module ulenc_checker #(
  parameter int LINE_BYTES = 45
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  ulenc_pkg::in_item_t        in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  ulenc_pkg::out_item_t       out_data_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [ulenc_pkg::CfgW-1:0] cfg_data_i,
  output int                         errors_o,
  output int                         backlog_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ulenc_pkg::CfgW-1:0]  lines_per_sum;
  int                          line_pos;
  logic [ulenc_pkg::PendW-1:0] held_bytes;
  logic [5:0]                  lines_done;
  logic [ulenc_pkg::SumW-1:0]  byte_sum;
  int                          error_count;
  ulenc_pkg::out_item_t        encoded_q[$];

  function automatic logic [6:0] to_char(input logic [5:0] v);
    return (v == 6'd0) ? ulenc_pkg::CharZero : ({1'b0, v} + ulenc_pkg::CharBias);
  endfunction

  task automatic push_text(input logic [6:0] c);
    ulenc_pkg::out_item_t r;
    r.kind       = ulenc_pkg::KIND_TEXT;
    r.text_char  = c;
    r.checksum   = '0;
    r.end_of_run = 1'b0;
    encoded_q.push_back(r);
  endtask

  task automatic push_sum();
    ulenc_pkg::out_item_t r;
    r.kind       = ulenc_pkg::KIND_CHECKSUM;
    r.text_char  = '0;
    r.checksum   = byte_sum;
    r.end_of_run = 1'b0;
    encoded_q.push_back(r);
    byte_sum   = '0;
    lines_done = '0;
  endtask

  task automatic push_group(input logic [ulenc_pkg::GrpW-1:0] g);
    for (int k = 3; k >= 0; k--) begin
      push_text(to_char(g[6*k +: 6]));
    end
  endtask

  task automatic encode_byte(input logic [7:0] b);
    int phase;
    phase = line_pos % 3;
    if (line_pos == 0) begin
      push_text(7'(32 + LINE_BYTES));
    end
    byte_sum = byte_sum + {{(ulenc_pkg::SumW-8){1'b0}}, b};
    case (phase)
      0: held_bytes = {8'h00, b};
      1: held_bytes = {held_bytes[7:0], b};
      default: push_group({held_bytes, b});
    endcase
    line_pos++;
    if (line_pos >= LINE_BYTES) begin
      // A line length that is not a multiple of three leaves a partial group to pad.
      phase = line_pos % 3;
      if (phase == 1) begin
        push_group({held_bytes[7:0], 16'h0000});
      end else if (phase == 2) begin
        push_group({held_bytes, 8'h00});
      end
      push_text(ulenc_pkg::CharCr);
      push_text(ulenc_pkg::CharLf);
      line_pos   = 0;
      held_bytes = '0;
      lines_done = lines_done + 6'd1;
      if (lines_done == lines_per_sum) begin
        push_sum();
      end
    end
  endtask

  task automatic encode_input(input ulenc_pkg::in_item_t it);
    int                   first;
    ulenc_pkg::out_item_t tail;
    first = encoded_q.size();
    encode_byte(it.data_byte);
    if (it.last) begin
      // The rest of the line is filled with zero bytes, which leave the sum unchanged.
      while (line_pos != 0) begin
        encode_byte(8'h00);
      end
      held_bytes = '0;
      if (lines_done != 0) begin
        push_sum();
      end
    end
    if (encoded_q.size() > first) begin
      tail = encoded_q.pop_back();
      tail.end_of_run = 1'b1;
      encoded_q.push_back(tail);
    end
  endtask

  task automatic check_result(input ulenc_pkg::out_item_t got);
    ulenc_pkg::out_item_t want;
    logic                 bad;
    if (encoded_q.size() == 0) begin
      $error("unexpected result: kind %0d, text_char %h, checksum %h, end_of_run %b",
             got.kind, got.text_char, got.checksum, got.end_of_run);
      error_count++;
    end else begin
      want = encoded_q.pop_front();
      bad  = 1'b0;
      if (got.kind != want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        bad = 1'b1;
      end
      if (got.text_char != want.text_char) begin
        $error("text_char: expected %h, actual %h", want.text_char, got.text_char);
        bad = 1'b1;
      end
      if (got.checksum != want.checksum) begin
        $error("checksum: expected %h, actual %h", want.checksum, got.checksum);
        bad = 1'b1;
      end
      if (got.end_of_run != want.end_of_run) begin
        $error("end_of_run: expected %b, actual %b", want.end_of_run, got.end_of_run);
        bad = 1'b1;
      end
      if (bad) begin
        error_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_per_sum = ulenc_pkg::LinesPerSumReset;
      line_pos      = 0;
      held_bytes    = '0;
      lines_done    = '0;
      byte_sum      = '0;
      error_count   = 0;
      encoded_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        lines_per_sum = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        encode_input(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(out_data_i);
      end
    end
    errors_o  <= error_count;
    backlog_o <= encoded_q.size();
  end

endmodule

>>> verif/tb.sv
// Top of the uuencode line encoder testbench: clock, reset, stimulus, output stalls and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     LineBytes   = 45;
  localparam int     Period      = 12;
  localparam int     TailCycles  = 24;
  localparam int     ChunkQuota  = 32;
  localparam longint LimitCycles = 1_000_000;

  localparam logic [7:0] EdgeBytes [12] = '{
    8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
    8'h04, 8'h10, 8'h41, 8'h80, 8'h01, 8'hFC
  };

  logic                       clk   = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid;
  logic                       in_stall;
  ulenc_pkg::in_item_t        in_data;
  logic                       out_valid;
  logic                       out_stall;
  ulenc_pkg::out_item_t       out_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [ulenc_pkg::CfgW-1:0] cfg_data;
  int                         errors;
  int                         backlog;
  bit                         no_gaps = 1'b0;

  always #(Period / 2) clk = ~clk;

  uuencode_line_encoder_core #(
    .LINE_BYTES(LineBytes)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  ulenc_checker #(
    .LINE_BYTES(LineBytes)
  ) encode_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .backlog_o   (backlog)
  );

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = 8'h00;
      1: b = 8'hFF;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ulenc_pkg::in_item_t'{data_byte: b, last: lst};
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every predicted result has been seen, then lets the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) begin
      @(posedge clk);
    end
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic write_lines_per_sum(input logic [ulenc_pkg::CfgW-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly chunks closed by a last byte; a few chunks stop short or carry a stray last.
  task automatic run_chunks(input int quota);
    int   sent;
    int   len;
    int   i;
    logic lst;
    sent = 0;
    while (sent < quota) begin
      len     = $urandom_range(1, 60);
      no_gaps = ($urandom_range(0, 4) == 0);
      for (i = 0; i < len; i++) begin
        if (i == len - 1) begin
          lst = ($urandom_range(0, 7) != 0);
        end else begin
          lst = ($urandom_range(0, 39) == 0);
        end
        send_byte(pick_byte(), lst);
      end
      sent += len;
    end
    no_gaps = 1'b0;
  endtask

  initial begin : sink
    int hold;
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && rst_n));
    end
  end

  initial begin : stimulus
    int k;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes at the reset setting, then a last byte in mid-line.
    foreach (EdgeBytes[j]) begin
      send_byte(EdgeBytes[j], 1'b0);
    end
    send_byte(8'h5A, 1'b1);

    // With one line per checksum the zero fill flushes the sum, so the last byte adds none.
    write_lines_per_sum(6'd1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b1);
    send_byte(8'h00, 1'b1);

    write_lines_per_sum(6'd1);
    run_chunks(ChunkQuota);
    write_lines_per_sum(6'd63);
    run_chunks(ChunkQuota);
    write_lines_per_sum(6'($urandom_range(2, 9)));
    run_chunks(ChunkQuota);
    write_lines_per_sum(6'd3);
    run_chunks(ChunkQuota);
    write_lines_per_sum(ulenc_pkg::LinesPerSumReset);
    run_chunks(ChunkQuota);

    // A register value of zero never matches a short line count, so only the last byte flushes.
    write_lines_per_sum(6'd0);
    no_gaps = ($urandom_range(0, 1) == 0);
    for (k = 0; k < LineBytes; k++) begin
      send_byte(pick_byte(), 1'b0);
    end
    no_gaps = 1'b0;
    send_byte(pick_byte(), 1'b0);
    send_byte(pick_byte(), 1'b0);
    send_byte(pick_byte(), 1'b1);

    settle();
    if (errors == 0 && backlog == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LimitCycles * Period);
    $display("tb failed");
    $finish;
  end

endmodule

>>> filelist.f
sv/ulenc_pkg.sv
sv/ulenc_front.sv
sv/ulenc_cmd_fifo.sv
sv/ulenc_back.sv
sv/uuencode_line_encoder_core.sv
sv/ulenc_checker.sv
verif/ulenc_checker.sv
verif/tb.sv
